// ----- rtl/arlc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the AT response line classifier.
// No dependencies; imported by every module of the block.
package arlc_pkg;

    // Default line buffer depth and command queue depth
    localparam int LINE_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH    = 4;

    // Stream widths
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 2;

    // Line framing and length parsing characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // Largest payload run emitted for one line
    localparam logic [5:0] MAX_PAYLOAD = 6'd63;

    // Result kinds
    localparam logic [1:0] KIND_ABSORB  = 2'd0;
    localparam logic [1:0] KIND_EVENT   = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // Line event codes
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_IPD   = 3'd1;
    localparam logic [2:0] EV_READY = 3'd2;
    localparam logic [2:0] EV_GOTIP = 3'd3;
    localparam logic [2:0] EV_OK    = 3'd4;
    localparam logic [2:0] EV_ERROR = 3'd5;

    // Command passed from the front end to the back end
    typedef enum logic [1:0] {
        CMD_ACK   = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_SCAN  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] code;
        logic [5:0] plen;
        logic [7:0] pbyte;
        logic [4:0] flags;
        logic       last;
    } result_t;

endpackage

// ----- rtl/at_response_line_classifier_core.sv -----
`timescale 1ns / 1ps
// Top level of the AT response line classifier.
// Depends on arlc_pkg, arlc_front, arlc_queue and arlc_back.
//
// Usage:
//   The slave channel takes one item per handshake: tuser is the operation
//   (0 receive the byte in tdata, 1 clear the sticky status flags).
//   Bytes are gathered into a line of LINE_DEPTH bytes; CR LF ends a line,
//   which is then scanned for +IPD, ready, GOT IP, OK and ERROR.
//   The master channel gives one result per handshake: tuser is the result
//   kind (0 absorbed, 1 line event, 2 payload byte), tlast marks the final
//   result of an input item, tdata carries code, length, byte and flags.
// Ordering and throughput:
//   An absorbed byte or a clear passes the queue and the result register;
//   the back end retires one such item a cycle unless the output stalls.
//   A line end is scanned one byte a cycle through the line memory's
//   single read port, then each payload byte is read and emitted in turn.
//   A four-entry command queue keeps accepting bytes while a scan runs.
// Reset and stalls:
//   aresetn (synchronous, active low) empties the queue, the line and the
//   flags; the line memory needs no clearing. While m_axis_tready is low
//   a valid result is held and the back end waits before loading another;
//   input is taken until the queue is full.
module at_response_line_classifier_core #(
    parameter int LINE_DEPTH = arlc_pkg::LINE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [arlc_pkg::S_DATA_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic                            s_axis_tuser,   // [0] operation
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] event_code, [8:3] payload_length, [16:9] payload_byte,
    // [21:17] status_flags, [23:22] zero
    output logic [arlc_pkg::M_DATA_W-1:0]   m_axis_tdata,
    output logic [arlc_pkg::M_USER_W-1:0]   m_axis_tuser,   // [1:0] result_kind
    output logic                            m_axis_tlast    // last
);
    import arlc_pkg::*;

    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int FILL_W = $clog2(LINE_DEPTH + 1);

    logic              q_full, q_push, q_empty, q_pop;
    cmd_t              push_cmd, head_cmd;
    logic [ADDR_W-1:0] push_addr, head_addr;
    result_t           result;

    // Accept and classify items
    arlc_front #(
        .LINE_DEPTH (LINE_DEPTH),
        .ADDR_W     (ADDR_W),
        .FILL_W     (FILL_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_byte  (s_axis_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd),
        .q_addr   (push_addr)
    );

    // Decouple the two ends
    arlc_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .push_addr (push_addr),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_cmd  (head_cmd),
        .head_addr (head_addr)
    );

    // Carry out commands and emit results
    arlc_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_cmd      (head_cmd),
        .q_addr     (head_addr),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the result item
    assign m_axis_tdata = {2'b00, result.flags, result.pbyte, result.plen, result.code};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule

// ----- rtl/arlc_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input items, tracks line fill and CR state, issues commands.
// Depends on arlc_pkg.
module arlc_front #(
    parameter int LINE_DEPTH = arlc_pkg::LINE_DEPTH_DEF,
    parameter int ADDR_W     = $clog2(LINE_DEPTH),
    parameter int FILL_W     = $clog2(LINE_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_op,
    input  logic [7:0]          in_byte,
    input  logic                q_full,
    output logic                q_push,
    output arlc_pkg::cmd_t      q_cmd,
    output logic [ADDR_W-1:0]   q_addr
);
    import arlc_pkg::*;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              prev_cr_reg, prev_cr_next;
    logic [FILL_W-1:0] fill_dec;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign fill_dec = fill_reg - 1'b1;

    // Classify the item and work out the next line state
    always_comb begin
        fill_next    = fill_reg;
        prev_cr_next = prev_cr_reg;
        q_cmd.kind   = CMD_ACK;
        q_cmd.data   = in_byte;
        q_addr       = fill_reg[ADDR_W-1:0];
        if (in_op) begin
            q_cmd.kind = CMD_CLEAR;
        end else if (fill_reg == '0) begin
            // skip a leading CR or LF
            if (in_byte != CH_CR && in_byte != CH_LF) begin
                q_cmd.kind   = CMD_WRITE;
                fill_next    = FILL_W'(1);
                prev_cr_next = 1'b0;
            end
        end else if (fill_reg == FILL_W'(LINE_DEPTH)) begin
            // drop the byte and discard the overlong line
            fill_next = '0;
        end else if (prev_cr_reg && in_byte == CH_LF) begin
            // line complete: hand over its length without the final CR
            q_cmd.kind = CMD_SCAN;
            q_addr     = fill_dec[ADDR_W-1:0];
            fill_next  = '0;
        end else begin
            q_cmd.kind   = CMD_WRITE;
            fill_next    = fill_reg + 1'b1;
            prev_cr_next = (in_byte == CH_CR);
        end
    end

    // Advance line state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            prev_cr_reg <= 1'b0;
        end else if (q_push) begin
            fill_reg    <= fill_next;
            prev_cr_reg <= prev_cr_next;
        end
    end

endmodule

// ----- rtl/arlc_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on arlc_pkg.
module arlc_queue #(
    parameter int ADDR_W = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  arlc_pkg::cmd_t      push_cmd,
    input  logic [ADDR_W-1:0]   push_addr,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output arlc_pkg::cmd_t      head_cmd,
    output logic [ADDR_W-1:0]   head_addr
);
    import arlc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              cmd_q  [QUEUE_DEPTH];
    logic [ADDR_W-1:0] addr_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_cmd  = cmd_q[rd_ptr_reg];
    assign head_addr = addr_q[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            cmd_q[wr_ptr_reg]  <= push_cmd;
            addr_q[wr_ptr_reg] <= push_addr;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/arlc_back.sv -----
`timescale 1ns / 1ps
// Back end: line memory, pattern scan, event and payload emission, output register.
// Depends on arlc_pkg.
module arlc_back #(
    parameter int LINE_DEPTH = arlc_pkg::LINE_DEPTH_DEF,
    parameter int ADDR_W     = $clog2(LINE_DEPTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  arlc_pkg::cmd_t      q_cmd,
    input  logic [ADDR_W-1:0]   q_addr,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output arlc_pkg::result_t   out_result
);
    import arlc_pkg::*;

    localparam int CMP_W = (ADDR_W > 8) ? ADDR_W : 8;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_SCAN  = 5'b00010,
        B_EVENT = 5'b00100,
        B_PREAD = 5'b01000,
        B_PEMIT = 5'b10000
    } back_state_t;

    typedef enum logic [3:0] {
        IP_NONE   = 4'b0001,
        IP_COMMA  = 4'b0010,
        IP_DIGITS = 4'b0100,
        IP_DONE   = 4'b1000
    } ipd_phase_t;

    back_state_t       state_reg, state_next;
    ipd_phase_t        phase_reg, phase_next;
    logic [4:0]        flags_reg, flags_next;
    logic [4:0]        found_reg, found_next;
    logic [4:0][7:0]   win_reg, win_next;
    logic [7:0]        acc_reg, acc_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0] n_reg, n_next;
    logic [ADDR_W-1:0] issue_reg, issue_next;
    logic [ADDR_W-1:0] data_idx_reg, data_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [5:0]        len_reg, len_next;
    logic [ADDR_W-1:0] pay_idx_reg, pay_idx_next;
    logic [5:0]        pay_cnt_reg, pay_cnt_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_result_reg, out_result_next;

    logic [7:0]        line_mem [LINE_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              out_free;
    logic              load;
    result_t           ld_result;
    logic [7:0]        ch;
    logic [4:0]        hits;
    logic [7:0]        acc_x10;
    logic [2:0]        ev_code;
    logic [4:0]        ev_bit;
    logic [ADDR_W-1:0] left;
    logic [CMP_W-1:0]  acc_ext, left_ext, min_al;
    logic [5:0]        len_calc;
    logic [5:0]        pay_cnt_inc;
    logic              pay_last;

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign ch         = rd_data_reg;

    // Match each pattern ending at the byte just read
    assign hits[0] = win_reg[2] == "+" && win_reg[1] == "I" && win_reg[0] == "P" && ch == "D";
    assign hits[1] = win_reg[3] == "r" && win_reg[2] == "e" && win_reg[1] == "a"
                     && win_reg[0] == "d" && ch == "y";
    assign hits[2] = win_reg[4] == "G" && win_reg[3] == "O" && win_reg[2] == "T"
                     && win_reg[1] == " " && win_reg[0] == "I" && ch == "P";
    assign hits[3] = win_reg[0] == "O" && ch == "K";
    assign hits[4] = win_reg[3] == "E" && win_reg[2] == "R" && win_reg[1] == "R"
                     && win_reg[0] == "O" && ch == "R";

    assign acc_x10 = {acc_reg[4:0], 3'b000} + {acc_reg[6:0], 1'b0};

    // Pick the event by priority and clamp the payload length
    always_comb begin
        if (found_reg[0]) begin
            ev_code = EV_IPD;
            ev_bit  = 5'b00001;
        end else if (found_reg[1]) begin
            ev_code = EV_READY;
            ev_bit  = 5'b00010;
        end else if (found_reg[2]) begin
            ev_code = EV_GOTIP;
            ev_bit  = 5'b00100;
        end else if (found_reg[3]) begin
            ev_code = EV_OK;
            ev_bit  = 5'b01000;
        end else if (found_reg[4]) begin
            ev_code = EV_ERROR;
            ev_bit  = 5'b10000;
        end else begin
            ev_code = EV_NONE;
            ev_bit  = 5'b00000;
        end
        left     = (phase_reg == IP_DONE) ? (n_reg - start_reg) : '0;
        acc_ext  = CMP_W'(acc_reg);
        left_ext = CMP_W'(left);
        min_al   = (acc_ext < left_ext) ? acc_ext : left_ext;
        len_calc = (min_al > CMP_W'(MAX_PAYLOAD)) ? MAX_PAYLOAD : min_al[5:0];
    end

    assign pay_cnt_inc = pay_cnt_reg + 6'd1;
    assign pay_last    = (pay_cnt_inc == len_reg);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        flags_next    = flags_reg;
        found_next    = found_reg;
        win_next      = win_reg;
        acc_next      = acc_reg;
        start_next    = start_reg;
        n_next        = n_reg;
        issue_next    = issue_reg;
        data_idx_next = issue_reg;
        rd_vld_next   = 1'b0;
        len_next      = len_reg;
        pay_idx_next  = pay_idx_reg;
        pay_cnt_next  = pay_cnt_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = issue_reg;
        load          = 1'b0;
        ld_result     = '0;

        case (state_reg)
            B_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_WRITE: begin
                            mem_we         = 1'b1;
                            load           = 1'b1;
                            ld_result.kind = KIND_ABSORB;
                            ld_result.last = 1'b1;
                        end
                        CMD_CLEAR: begin
                            flags_next     = '0;
                            load           = 1'b1;
                            ld_result.kind = KIND_ABSORB;
                            ld_result.last = 1'b1;
                        end
                        CMD_SCAN: begin
                            n_next     = q_addr;
                            issue_next = '0;
                            win_next   = '0;
                            found_next = '0;
                            phase_next = IP_NONE;
                            acc_next   = '0;
                            start_next = '0;
                            state_next = B_SCAN;
                        end
                        default: begin
                            load           = 1'b1;
                            ld_result.kind = KIND_ABSORB;
                            ld_result.last = 1'b1;
                        end
                    endcase
                end
            end

            B_SCAN: begin
                // issue one read a cycle over the line
                if (issue_reg != n_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr   = issue_reg;
                    issue_next  = issue_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                // process the byte read last cycle
                if (rd_vld_reg) begin
                    win_next   = {win_reg[3:0], ch};
                    found_next = found_reg | hits;
                    case (phase_reg)
                        IP_NONE: begin
                            if (hits[0]) begin
                                phase_next = IP_COMMA;
                            end
                        end
                        IP_COMMA: begin
                            if (ch == CH_COMMA) begin
                                phase_next = IP_DIGITS;
                            end
                        end
                        IP_DIGITS: begin
                            if (ch == CH_COLON) begin
                                phase_next = IP_DONE;
                                start_next = data_idx_reg + 1'b1;
                            end else begin
                                acc_next = acc_x10 + ch + 8'd208;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (issue_reg == n_reg && !rd_vld_reg) begin
                    state_next = B_EVENT;
                end
            end

            B_EVENT: begin
                if (out_free) begin
                    flags_next     = flags_reg | ev_bit;
                    load           = 1'b1;
                    ld_result.kind = KIND_EVENT;
                    ld_result.code = ev_code;
                    if (found_reg[0] && len_calc != '0) begin
                        ld_result.plen = len_calc;
                        ld_result.last = 1'b0;
                        len_next       = len_calc;
                        pay_idx_next   = start_reg;
                        pay_cnt_next   = '0;
                        state_next     = B_PREAD;
                    end else begin
                        ld_result.last = 1'b1;
                        state_next     = B_IDLE;
                    end
                end
            end

            B_PREAD: begin
                mem_re     = 1'b1;
                mem_raddr  = pay_idx_reg;
                state_next = B_PEMIT;
            end

            B_PEMIT: begin
                if (out_free) begin
                    load            = 1'b1;
                    ld_result.kind  = KIND_PAYLOAD;
                    ld_result.code  = EV_IPD;
                    ld_result.plen  = len_reg;
                    ld_result.pbyte = rd_data_reg;
                    ld_result.last  = pay_last;
                    if (pay_last) begin
                        state_next = B_IDLE;
                    end else begin
                        pay_cnt_next = pay_cnt_inc;
                        pay_idx_next = pay_idx_reg + 1'b1;
                        state_next   = B_PREAD;
                    end
                end
            end

            default: begin
                state_next = B_IDLE;
            end
        endcase

        // every result shows the flags after this item
        ld_result.flags = flags_next;
    end

    // Output register: load a result or drop the one taken
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (load) begin
            out_valid_next  = 1'b1;
            out_result_next = ld_result;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Line memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[q_addr] <= q_cmd.data;
        end
        if (mem_re) begin
            rd_data_reg <= line_mem[mem_raddr];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            phase_reg     <= IP_NONE;
            flags_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scan and payload working registers
    always_ff @(posedge aclk) begin
        found_reg      <= found_next;
        win_reg        <= win_next;
        acc_reg        <= acc_next;
        start_reg      <= start_next;
        n_reg          <= n_next;
        issue_reg      <= issue_next;
        data_idx_reg   <= data_idx_next;
        len_reg        <= len_next;
        pay_idx_reg    <= pay_idx_next;
        pay_cnt_reg    <= pay_cnt_next;
        out_result_reg <= out_result_next;
    end

endmodule

// ----- rtl/arlc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the AT response line classifier, bound to the top level.
// Depends on arlc_pkg and at_response_line_classifier_core.
module arlc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [arlc_pkg::M_DATA_W-1:0]   m_axis_tdata,
    input logic [arlc_pkg::M_USER_W-1:0]   m_axis_tuser,
    input logic                            m_axis_tlast
);
    import arlc_pkg::*;

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // No result straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // An absorbed item gives one result with no event
    a_absorb_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_ABSORB |->
        m_axis_tlast && m_axis_tdata[2:0] == EV_NONE && m_axis_tdata[16:3] == '0)
        else $error("absorbed item result malformed");

    // Payload bytes belong to an ipd line with a nonzero length
    a_payload_ipd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD |->
        m_axis_tdata[2:0] == EV_IPD && m_axis_tdata[8:3] != '0)
        else $error("payload result outside an ipd line");

    // Only defined result kinds appear
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser == KIND_ABSORB || m_axis_tuser == KIND_EVENT
        || m_axis_tuser == KIND_PAYLOAD)
        else $error("undefined result kind");

endmodule

bind at_response_line_classifier_core arlc_checker u_arlc_checker (.*);
